[rtl/midi_pkg.sv]
`timescale 1ns / 1ps

package midi_pkg;

   localparam int LEN_W = 28;

   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_EOX   = 8'hF7;
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] DATA_MASK    = 8'h7F;
   localparam logic [7:0] STATUS_BIT   = 8'h80;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DATA1,
      PH_DATA2,
      PH_VENDOR,
      PH_SXLIVE,
      PH_METATYPE,
      PH_LENGTH,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CHAN  = 3'd0,
      KIND_SYS   = 3'd1,
      KIND_SYSEX = 3'd2,
      KIND_META  = 3'd3,
      KIND_END   = 3'd4,
      KIND_ERR   = 3'd5
   } kind_type;

   // one queued event, optionally followed by a block end item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [1:0] data_count;
      logic [7:0] meta_kind;
      logic       with_end;
   } rsp_entry_type;

   // data bytes that follow a channel status, by high nibble
   function automatic logic [1:0] data_len(input logic [3:0] nibble);
      logic [1:0] len;
      begin
         case (nibble)
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
            4'hC, 4'hD:                    len = 2'd1;
            default:                       len = 2'd0;
         endcase
         return len;
      end
   endfunction

endpackage

[rtl/midi_byte_stream_parser.sv]
`timescale 1ns / 1ps
// Results are registered in the event queue before they appear on rsp.
// Throughput: one byte per cycle while the two-entry event queue after the parse logic
// is not full; the queue drains one item per cycle while rsp_tready is high, and a byte
// that closes a file block (payload plus end) yields two output items from one entry.
// Reset: synchronous, active high; parser idle, running status and file_mode cleared.
module midi_byte_stream_parser
   import midi_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] status_byte, [15:8] first_data,
                                    // [23:16] second_data, [25:24] data_count,
                                    // [33:26] meta_kind, [39:34] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // file_mode
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       running_status_ff, running_status_in;
   logic [7:0]       held_data_ff, held_data_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;
   logic [LEN_W-1:0] length_accum_ff, length_accum_in;
   logic [2:0]       length_bytes_ff, length_bytes_in;
   logic             block_is_meta_ff, block_is_meta_in;
   logic [7:0]       held_meta_kind_ff, held_meta_kind_in;
   logic             file_mode_ff;

   rsp_entry_type    queue_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff, sel_ff;
   logic [1:0]       count_ff;

   rsp_entry_type    result;
   rsp_entry_type    head;
   logic             result_valid;
   logic             req_xfer, rsp_xfer, push, pop;
   logic [7:0]       b;
   logic [1:0]       dlen;
   logic [7:0]       blk_status;
   logic [7:0]       blk_meta;
   logic [LEN_W-1:0] accum_next;
   logic [LEN_W-1:0] remaining_dec;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff != 2'd2);
   assign req_xfer   = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign dlen       = data_len(running_status_ff[7:4]);
   assign blk_status = block_is_meta_ff ? STATUS_META : STATUS_SYSEX;
   assign blk_meta   = block_is_meta_ff ? held_meta_kind_ff : 8'd0;
   assign accum_next = {length_accum_ff[LEN_W-8:0], b[6:0]};
   assign remaining_dec = remaining_ff - {{(LEN_W-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in          = phase_ff;
      running_status_in = running_status_ff;
      held_data_in      = held_data_ff;
      remaining_in      = remaining_ff;
      length_accum_in   = length_accum_ff;
      length_bytes_in   = length_bytes_ff;
      block_is_meta_in  = block_is_meta_ff;
      held_meta_kind_in = held_meta_kind_ff;
      result_valid      = 1'b0;
      result            = '{kind: KIND_SYS, status_byte: 8'd0, first_data: 8'd0,
                            second_data: 8'd0, data_count: 2'd0, meta_kind: 8'd0,
                            with_end: 1'b0};
      case (phase_ff)
         PH_IDLE: begin
            if ((b & STATUS_BIT) != 8'd0) begin
               running_status_in = b;
               if (data_len(b[7:4]) != 2'd0) begin
                  phase_in = PH_DATA1;
               end else if (b == STATUS_SYSEX) begin
                  block_is_meta_in  = 1'b0;
                  held_meta_kind_in = 8'd0;
                  if (file_mode_ff) begin
                     length_accum_in = '0;
                     length_bytes_in = 3'd0;
                     phase_in        = PH_LENGTH;
                  end else begin
                     phase_in = PH_VENDOR;
                  end
               end else if (b == STATUS_META && file_mode_ff) begin
                  block_is_meta_in = 1'b1;
                  phase_in         = PH_METATYPE;
               end else begin
                  result_valid       = 1'b1;
                  result.kind        = KIND_SYS;
                  result.status_byte = b;
               end
            end else if (dlen == 2'd1) begin
               result_valid       = 1'b1;
               result.kind        = KIND_CHAN;
               result.status_byte = running_status_ff;
               result.first_data  = b;
               result.data_count  = 2'd1;
            end else if (dlen == 2'd2) begin
               held_data_in = b;
               phase_in     = PH_DATA2;
            end else begin
               result_valid       = 1'b1;
               result.kind        = KIND_ERR;
               result.status_byte = running_status_ff;
               result.first_data  = b;
            end
         end
         PH_DATA1: begin
            if (dlen == 2'd2) begin
               held_data_in = b;
               phase_in     = PH_DATA2;
            end else begin
               result_valid       = 1'b1;
               result.kind        = KIND_CHAN;
               result.status_byte = running_status_ff;
               result.first_data  = b;
               result.data_count  = 2'd1;
               phase_in           = PH_IDLE;
            end
         end
         PH_DATA2: begin
            result_valid       = 1'b1;
            result.kind        = KIND_CHAN;
            result.status_byte = running_status_ff;
            result.first_data  = held_data_ff;
            result.second_data = b;
            result.data_count  = 2'd2;
            phase_in           = PH_IDLE;
         end
         PH_VENDOR: begin
            // drop the vendor byte
            phase_in = PH_SXLIVE;
         end
         PH_SXLIVE: begin
            result_valid       = 1'b1;
            result.status_byte = STATUS_SYSEX;
            if (b == STATUS_EOX) begin
               result.kind = KIND_END;
               phase_in    = PH_IDLE;
            end else begin
               result.kind       = KIND_SYSEX;
               result.first_data = b;
            end
         end
         PH_METATYPE: begin
            held_meta_kind_in = b;
            length_accum_in   = '0;
            length_bytes_in   = 3'd0;
            phase_in          = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_accum_in = accum_next;
            length_bytes_in = length_bytes_ff + 3'd1;
            if ((b & STATUS_BIT) != 8'd0) begin
               if (length_bytes_in >= 3'(MAX_LENGTH_BYTES)) begin
                  result_valid       = 1'b1;
                  result.kind        = KIND_ERR;
                  result.status_byte = blk_status;
                  result.first_data  = b;
                  result.meta_kind   = blk_meta;
                  phase_in           = PH_IDLE;
               end
            end else if (accum_next == '0) begin
               result_valid       = 1'b1;
               result.kind        = KIND_END;
               result.status_byte = blk_status;
               result.meta_kind   = blk_meta;
               phase_in           = PH_IDLE;
            end else begin
               remaining_in = accum_next;
               phase_in     = PH_PAYLOAD;
            end
         end
         default: begin
            result_valid       = 1'b1;
            result.kind        = block_is_meta_ff ? KIND_META : KIND_SYSEX;
            result.status_byte = blk_status;
            result.first_data  = b;
            result.meta_kind   = blk_meta;
            remaining_in       = remaining_dec;
            if (remaining_dec == '0) begin
               result.with_end = 1'b1;
               phase_in        = PH_IDLE;
            end
         end
      endcase
   end

   // output side: head entry, then its end item when one is attached
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign pop        = rsp_xfer && (sel_ff || !head.with_end);
   assign push       = req_xfer && result_valid;

   always_comb begin
      if (sel_ff) begin
         rsp_tuser = KIND_END;
         rsp_tdata = {6'd0, head.meta_kind, 2'd0, 8'd0, 8'd0, head.status_byte};
         rsp_tlast = 1'b1;
      end else begin
         rsp_tuser = head.kind;
         rsp_tdata = {6'd0, head.meta_kind, head.data_count, head.second_data,
                      head.first_data, head.status_byte};
         rsp_tlast = !head.with_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         running_status_ff <= 8'd0;
         held_data_ff      <= 8'd0;
         remaining_ff      <= '0;
         length_accum_ff   <= '0;
         length_bytes_ff   <= 3'd0;
         block_is_meta_ff  <= 1'b0;
         held_meta_kind_ff <= 8'd0;
         file_mode_ff      <= 1'b0;
         wr_ptr_ff         <= 1'b0;
         rd_ptr_ff         <= 1'b0;
         sel_ff            <= 1'b0;
         count_ff          <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            file_mode_ff <= csr_data;
         end
         if (req_xfer) begin
            phase_ff          <= phase_in;
            running_status_ff <= running_status_in;
            held_data_ff      <= held_data_in;
            remaining_ff      <= remaining_in;
            length_accum_ff   <= length_accum_in;
            length_bytes_ff   <= length_bytes_in;
            block_is_meta_ff  <= block_is_meta_in;
            held_meta_kind_ff <= held_meta_kind_in;
         end
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            sel_ff    <= 1'b0;
         end else if (rsp_xfer) begin
            // advance to the attached end item
            sel_ff <= 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("event queue count out of range");

   a_sel_has_end: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (rsp_tvalid && head.with_end))
      else $error("end item selected without an attached end");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != '0))
      else $error("payload phase with nothing remaining");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LENGTH) |-> (length_bytes_ff < 3'(MAX_LENGTH_BYTES)))
      else $error("length prefix longer than allowed");

endmodule
